// ===== rtl/fbsc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Frustum cull package
// Shared types, field widths and result codes for the frustum cull unit.
// ----------------------------------------------------------------------------
package fbsc_pkg;

    // Plane register layout: nx, ny, nz (Q1.14) over d (Q12.4).
    localparam int PLANE_REGS  = 6;
    localparam int PLANE_W     = 64;
    localparam int CFG_INDEX_W = 3;
    localparam int COORD_W     = 16;
    localparam int HALF_W      = 15;

    // Scale step that brings Q12.4 terms up to the Q.18 product scale.
    localparam int SCALE_SHIFT = 14;

    // Signed product n*c, unsigned product |n|*h, and the accumulator.
    localparam int PROD_W  = 2 * COORD_W;
    localparam int RPROD_W = COORD_W + HALF_W;
    localparam int ACC_W   = 37;

    localparam logic OP_BOX    = 1'b0;
    localparam logic OP_SPHERE = 1'b1;

    localparam logic [1:0] VERDICT_INSIDE    = 2'd0;
    localparam logic [1:0] VERDICT_INTERSECT = 2'd1;
    localparam logic [1:0] VERDICT_OUTSIDE   = 2'd2;

    // One request as it travels down the row of plane cells.
    typedef struct packed {
        logic                      operation;
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic signed [COORD_W-1:0] center_z;
        logic [HALF_W-1:0]         half_x;
        logic [HALF_W-1:0]         half_y;
        logic [HALF_W-1:0]         half_z;
        logic [HALF_W-1:0]         sphere_radius;
        logic                      outside;
        logic                      straddle;
    } item_t;

endpackage
`default_nettype wire

// ===== rtl/fbsc_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Frustum cull plane cell
// Tests the passing request against one plane in three stages (products,
// distance and radius sums, sign tests) and ORs the outcome into its flags.
// ----------------------------------------------------------------------------
module fbsc_cell (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [fbsc_pkg::PLANE_W-1:0]   plane,
    input  logic                           up_valid,
    output logic                           up_ready,
    input  fbsc_pkg::item_t                up_item,
    output logic                           dn_valid,
    input  logic                           dn_ready,
    output fbsc_pkg::item_t                dn_item
);
    import fbsc_pkg::*;

    logic signed [COORD_W-1:0] nx;
    logic signed [COORD_W-1:0] ny;
    logic signed [COORD_W-1:0] nz;
    logic signed [COORD_W-1:0] pd;
    logic [COORD_W-1:0]        ax;
    logic [COORD_W-1:0]        ay;
    logic [COORD_W-1:0]        az;

    logic adv_a;
    logic adv_b;
    logic adv_c;

    // Stage A: products
    logic                      a_valid_reg;
    item_t                     a_item_reg;
    logic signed [PROD_W-1:0]  a_px_reg;
    logic signed [PROD_W-1:0]  a_py_reg;
    logic signed [PROD_W-1:0]  a_pz_reg;
    logic [RPROD_W-1:0]        a_rx_reg;
    logic [RPROD_W-1:0]        a_ry_reg;
    logic [RPROD_W-1:0]        a_rz_reg;
    logic signed [PROD_W-1:0]  a_px_next;
    logic signed [PROD_W-1:0]  a_py_next;
    logic signed [PROD_W-1:0]  a_pz_next;
    logic [RPROD_W-1:0]        a_rx_next;
    logic [RPROD_W-1:0]        a_ry_next;
    logic [RPROD_W-1:0]        a_rz_next;

    // Stage B: distance and projected radius
    logic                      b_valid_reg;
    item_t                     b_item_reg;
    logic [ACC_W-1:0]          b_dist_reg;
    logic [ACC_W-1:0]          b_r_reg;
    logic [ACC_W-1:0]          b_dist_next;
    logic [ACC_W-1:0]          b_r_next;
    logic [ACC_W-1:0]          box_r;
    logic [ACC_W-1:0]          sphere_r;

    // Stage C: flags
    logic                      c_valid_reg;
    item_t                     c_item_reg;
    item_t                     c_item_next;
    logic [ACC_W-1:0]          far_side;
    logic [ACC_W-1:0]          near_side;

    assign nx = plane[63:48];
    assign ny = plane[47:32];
    assign nz = plane[31:16];
    assign pd = plane[15:0];

    assign ax = nx[COORD_W-1] ? COORD_W'(-nx) : COORD_W'(nx);
    assign ay = ny[COORD_W-1] ? COORD_W'(-ny) : COORD_W'(ny);
    assign az = nz[COORD_W-1] ? COORD_W'(-nz) : COORD_W'(nz);

    // A stage moves when it is empty or the stage after it moves.
    assign adv_c    = !c_valid_reg || dn_ready;
    assign adv_b    = !b_valid_reg || adv_c;
    assign adv_a    = !a_valid_reg || adv_b;
    assign up_ready = adv_a;

    assign a_px_next = nx * up_item.center_x;
    assign a_py_next = ny * up_item.center_y;
    assign a_pz_next = nz * up_item.center_z;
    assign a_rx_next = ax * up_item.half_x;
    assign a_ry_next = ay * up_item.half_y;
    assign a_rz_next = az * up_item.half_z;

    always_comb
    begin
        b_dist_next = {{(ACC_W-PROD_W){a_px_reg[PROD_W-1]}}, a_px_reg}
                    + {{(ACC_W-PROD_W){a_py_reg[PROD_W-1]}}, a_py_reg}
                    + {{(ACC_W-PROD_W){a_pz_reg[PROD_W-1]}}, a_pz_reg}
                    + {{(ACC_W-COORD_W-SCALE_SHIFT){pd[COORD_W-1]}}, pd,
                       {SCALE_SHIFT{1'b0}}};
        box_r       = {{(ACC_W-RPROD_W){1'b0}}, a_rx_reg}
                    + {{(ACC_W-RPROD_W){1'b0}}, a_ry_reg}
                    + {{(ACC_W-RPROD_W){1'b0}}, a_rz_reg};
        sphere_r    = {{(ACC_W-HALF_W-SCALE_SHIFT){1'b0}}, a_item_reg.sphere_radius,
                       {SCALE_SHIFT{1'b0}}};
        b_r_next    = (a_item_reg.operation == OP_SPHERE) ? sphere_r : box_r;
    end

    // The volume is fully behind the plane when even its far side is negative;
    // it straddles when only the near side is.
    always_comb
    begin
        far_side             = b_dist_reg + b_r_reg;
        near_side            = b_dist_reg - b_r_reg;
        c_item_next          = b_item_reg;
        c_item_next.outside  = b_item_reg.outside | far_side[ACC_W-1];
        c_item_next.straddle = b_item_reg.straddle | near_side[ACC_W-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv_a)
            begin
                a_valid_reg <= up_valid;
            end
            if (adv_b)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (adv_c)
            begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_a && up_valid)
        begin
            a_item_reg <= up_item;
            a_px_reg   <= a_px_next;
            a_py_reg   <= a_py_next;
            a_pz_reg   <= a_pz_next;
            a_rx_reg   <= a_rx_next;
            a_ry_reg   <= a_ry_next;
            a_rz_reg   <= a_rz_next;
        end
        if (adv_b && a_valid_reg)
        begin
            b_item_reg <= a_item_reg;
            b_dist_reg <= b_dist_next;
            b_r_reg    <= b_r_next;
        end
        if (adv_c && b_valid_reg)
        begin
            c_item_reg <= c_item_next;
        end
    end

    assign dn_valid = c_valid_reg;
    assign dn_item  = c_item_reg;

endmodule
`default_nettype wire

// ===== rtl/frustum_box_sphere_cull_unit.sv =====
`default_nettype none
// Each request passes the stages of every plane cell, then the output register.
// Throughput: one request per cycle while the output is not stalled; each plane cell
// is a three-stage pipeline and requests march through the cells one stage per cycle.
// Bubbles collapse, so a request is taken while a verdict waits at the output.
// Reset clears all pipeline valid bits and sets every plane register to zero.
// ----------------------------------------------------------------------------
// Frustum box and sphere cull unit
// Classifies a box or sphere as inside, intersecting or outside of up to six
// configured planes, one plane cell per plane.
// ----------------------------------------------------------------------------
module frustum_box_sphere_cull_unit #(
    parameter int PLANE_COUNT = 6
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [fbsc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [fbsc_pkg::PLANE_W-1:0]        cfg_data,

    input  logic                                item_valid,
    output logic                                item_stall,
    input  logic                                operation,
    input  logic signed [fbsc_pkg::COORD_W-1:0] center_x,
    input  logic signed [fbsc_pkg::COORD_W-1:0] center_y,
    input  logic signed [fbsc_pkg::COORD_W-1:0] center_z,
    input  logic [fbsc_pkg::HALF_W-1:0]         half_x,
    input  logic [fbsc_pkg::HALF_W-1:0]         half_y,
    input  logic [fbsc_pkg::HALF_W-1:0]         half_z,
    input  logic [fbsc_pkg::HALF_W-1:0]         sphere_radius,

    output logic                                result_valid,
    input  logic                                result_stall,
    output logic [1:0]                          verdict
);
    import fbsc_pkg::*;

    // Only six plane registers exist; a larger count adds no cells.
    localparam int CELL_COUNT = (PLANE_COUNT < PLANE_REGS) ? PLANE_COUNT : PLANE_REGS;

    logic [PLANE_W-1:0]   plane_reg [PLANE_REGS];

    logic [CELL_COUNT:0]  chain_valid;
    logic [CELL_COUNT:0]  chain_ready;
    item_t                chain_item [CELL_COUNT+1];

    logic                 out_valid_reg;
    logic [1:0]           verdict_reg;
    logic [1:0]           verdict_next;
    logic                 adv_out;

    // Configuration is always accepted.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PLANE_REGS; i++)
            begin
                plane_reg[i] <= '0;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            for (int i = 0; i < PLANE_REGS; i++)
            begin
                if (cfg_index == CFG_INDEX_W'(i))
                begin
                    plane_reg[i] <= cfg_data;
                end
            end
        end
    end

    always_comb
    begin
        chain_item[0]               = '0;
        chain_item[0].operation     = operation;
        chain_item[0].center_x      = center_x;
        chain_item[0].center_y      = center_y;
        chain_item[0].center_z      = center_z;
        chain_item[0].half_x        = half_x;
        chain_item[0].half_y        = half_y;
        chain_item[0].half_z        = half_z;
        chain_item[0].sphere_radius = sphere_radius;
    end

    assign chain_valid[0] = item_valid;
    assign item_stall     = !chain_ready[0];

    for (genvar g = 0; g < CELL_COUNT; g++)
    begin : g_cell
        fbsc_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .plane    (plane_reg[g]),
            .up_valid (chain_valid[g]),
            .up_ready (chain_ready[g]),
            .up_item  (chain_item[g]),
            .dn_valid (chain_valid[g+1]),
            .dn_ready (chain_ready[g+1]),
            .dn_item  (chain_item[g+1])
        );
    end

    // Output register: outside wins over intersecting.
    assign adv_out                 = !out_valid_reg || !result_stall;
    assign chain_ready[CELL_COUNT] = adv_out;

    always_comb
    begin
        priority if (chain_item[CELL_COUNT].outside)
        begin
            verdict_next = VERDICT_OUTSIDE;
        end
        else if (chain_item[CELL_COUNT].straddle)
        begin
            verdict_next = VERDICT_INTERSECT;
        end
        else
        begin
            verdict_next = VERDICT_INSIDE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv_out)
        begin
            out_valid_reg <= chain_valid[CELL_COUNT];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_out && chain_valid[CELL_COUNT])
        begin
            verdict_reg <= verdict_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign verdict      = verdict_reg;

    // With the output register empty every stage can move, so no request waits.
    a_empty_out_takes_request: assert property (
        @(posedge clk) disable iff (!rst_n)
        !result_valid |-> !item_stall
    ) else $error("request stalled while the output register is empty");

    a_verdict_code: assert property (
        @(posedge clk) disable iff (!rst_n)
        result_valid |-> (verdict == VERDICT_INSIDE) || (verdict == VERDICT_INTERSECT)
                         || (verdict == VERDICT_OUTSIDE)
    ) else $error("verdict carries an unused code");

    // A verdict taken with nothing arriving from the last cell leaves the output empty.
    a_output_drains: assert property (
        @(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall && !chain_valid[CELL_COUNT] |=> !result_valid
    ) else $error("output register did not drain");

endmodule
`default_nettype wire

// ===== bench/frustum_box_sphere_cull_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frustum cull unit testbench
// Loads plane sets through the configuration channel and streams boxes and
// spheres through the block. Each accepted request is classified by a local
// model of the six plane tests, and every verdict that comes back is compared
// in order against those predictions, with random gaps between requests and
// random stalls on the result side.
// ----------------------------------------------------------------------------
module frustum_box_sphere_cull_unit_tb;
    import fbsc_pkg::*;

    localparam int PLANE_COUNT   = 6;
    localparam int LATENCY       = 3 * PLANE_COUNT + 1;
    localparam int WATCHDOG_MAX  = 2000;
    localparam int REPORT_MAX    = 10;
    localparam int UNIT_NORMAL   = 1 << SCALE_SHIFT;
    localparam int RANDOM_PHASE  = 250;

    localparam logic [CFG_INDEX_W-1:0] REG_NEAR    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FAR     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LEFT    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_RIGHT   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_TOP     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_BOTTOM  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 3'd7;

    typedef struct packed {
        logic                      operation;
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic signed [COORD_W-1:0] center_z;
        logic [HALF_W-1:0]         half_x;
        logic [HALF_W-1:0]         half_y;
        logic [HALF_W-1:0]         half_z;
        logic [HALF_W-1:0]         sphere_radius;
    } cull_req_t;

    class cull_scoreboard;
        logic [PLANE_W-1:0] planes[PLANE_REGS];
        logic [1:0]         verdict_q[$];
        int                 failures;

        function new();
            foreach (planes[i])
            begin
                planes[i] = '0;
            end
            failures = 0;
        endfunction

        function void write_plane(logic [CFG_INDEX_W-1:0] idx, logic [PLANE_W-1:0] value);
            if (idx < PLANE_REGS)
            begin
                planes[idx] = value;
            end
        endfunction

        // Classify the volume against every plane; an outside plane wins over
        // any number of straddled ones.
        function void note_request(cull_req_t r);
            longint             nx, ny, nz, dv, cx, cy, cz, hx, hy, hz, rad, sdist, spread;
            logic               outside, straddle;
            logic [PLANE_W-1:0] p;
            cx = r.center_x;
            cy = r.center_y;
            cz = r.center_z;
            hx = r.half_x;
            hy = r.half_y;
            hz = r.half_z;
            rad = r.sphere_radius;
            rad = rad <<< SCALE_SHIFT;
            outside = 1'b0;
            straddle = 1'b0;
            for (int i = 0; i < PLANE_COUNT && i < PLANE_REGS; i++)
            begin
                p = planes[i];
                nx = $signed(p[63:48]);
                ny = $signed(p[47:32]);
                nz = $signed(p[31:16]);
                dv = $signed(p[15:0]);
                dv = dv <<< SCALE_SHIFT;
                sdist = nx * cx + ny * cy + nz * cz + dv;
                if (r.operation == OP_SPHERE)
                begin
                    if (sdist < -rad)
                        outside = 1'b1;
                    else if (sdist < rad)
                        straddle = 1'b1;
                end
                else
                begin
                    spread = (nx < 0 ? -nx : nx) * hx + (ny < 0 ? -ny : ny) * hy
                           + (nz < 0 ? -nz : nz) * hz;
                    if (sdist + spread < 0)
                        outside = 1'b1;
                    else if (sdist - spread < 0)
                        straddle = 1'b1;
                end
            end
            verdict_q.push_back(outside ? VERDICT_OUTSIDE :
                                (straddle ? VERDICT_INTERSECT : VERDICT_INSIDE));
        endfunction

        function void check_verdict(logic [1:0] got);
            logic [1:0] want;
            if (verdict_q.size() == 0)
            begin
                failures++;
                if (failures <= REPORT_MAX)
                    $display("verdict %0d arrived with no request pending", got);
                return;
            end
            want = verdict_q.pop_front();
            if (got !== want)
            begin
                failures++;
                if (failures <= REPORT_MAX)
                    $display("verdict mismatch: expected %0d, got %0d", want, got);
            end
        endfunction

        function int pending();
            return verdict_q.size();
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_W-1:0]    cfg_index;
    logic [PLANE_W-1:0]        cfg_data;
    logic                      item_valid;
    logic                      item_stall;
    logic                      operation;
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic signed [COORD_W-1:0] center_z;
    logic [HALF_W-1:0]         half_x;
    logic [HALF_W-1:0]         half_y;
    logic [HALF_W-1:0]         half_z;
    logic [HALF_W-1:0]         sphere_radius;
    logic                      result_valid;
    logic                      result_stall;
    logic [1:0]                verdict;

    cull_scoreboard sb;
    bit             burst;
    int             long_hold;
    int             hold_left;
    int             quiet_cycles;

    frustum_box_sphere_cull_unit #(
        .PLANE_COUNT(PLANE_COUNT)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .operation    (operation),
        .center_x     (center_x),
        .center_y     (center_y),
        .center_z     (center_z),
        .half_x       (half_x),
        .half_y       (half_y),
        .half_z       (half_z),
        .sphere_radius(sphere_radius),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .verdict      (verdict)
    );

    always #10 clk = ~clk;

    // Result side: the stall for the next verdict is drawn when one is taken.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            result_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else
        begin
            result_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && result_valid === 1'b1 && result_stall === 1'b0)
        begin
            sb.check_verdict(verdict);
            if (long_hold > 0)
            begin
                hold_left = long_hold;
                long_hold = 0;
            end
            else
            begin
                hold_left = burst ? 0 : $urandom_range(0, 7);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n !== 1'b1 || (item_valid && !item_stall) || (cfg_valid && cfg_ready)
            || (result_valid && !result_stall))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_MAX)
            begin
                $display("watchdog: no handshake for %0d cycles", WATCHDOG_MAX);
                $display("[frustum_box_sphere_cull_unit] ERROR");
                $finish;
            end
        end
    end

    function automatic cull_req_t make_req(logic op, int cx, int cy, int cz,
                                           int hx, int hy, int hz, int rad);
        cull_req_t r;
        r.operation     = op;
        r.center_x      = cx[COORD_W-1:0];
        r.center_y      = cy[COORD_W-1:0];
        r.center_z      = cz[COORD_W-1:0];
        r.half_x        = hx[HALF_W-1:0];
        r.half_y        = hy[HALF_W-1:0];
        r.half_z        = hz[HALF_W-1:0];
        r.sphere_radius = rad[HALF_W-1:0];
        return r;
    endfunction

    function automatic logic [PLANE_W-1:0] pack_plane(int nx, int ny, int nz, int d);
        return {nx[15:0], ny[15:0], nz[15:0], d[15:0]};
    endfunction

    // Mostly volumes near the frustum so all three verdicts show up, with some
    // full-range centers and the occasional huge extent.
    function automatic int rand_coord(bit wide);
        return wide ? int'($urandom()) : int'($urandom_range(0, 6000)) - 3000;
    endfunction

    function automatic int rand_extent();
        return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 32767) : $urandom_range(0, 1500);
    endfunction

    function automatic cull_req_t rand_volume();
        bit wide;
        wide = ($urandom_range(0, 3) == 0);
        return make_req($urandom_range(0, 1) ? OP_SPHERE : OP_BOX,
                        rand_coord(wide), rand_coord(wide), rand_coord(wide),
                        rand_extent(), rand_extent(), rand_extent(), rand_extent());
    endfunction

    task automatic offer_volume(input cull_req_t r);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 7);
        repeat (gap)
        begin
            @(negedge clk);
            item_valid <= 1'b0;
        end
        @(negedge clk);
        item_valid    <= 1'b1;
        operation     <= r.operation;
        center_x      <= r.center_x;
        center_y      <= r.center_y;
        center_z      <= r.center_z;
        half_x        <= r.half_x;
        half_y        <= r.half_y;
        half_z        <= r.half_z;
        sphere_radius <= r.sphere_radius;
        do
            @(posedge clk);
        while (item_stall);
        sb.note_request(r);
    endtask

    // Stop offering and let every outstanding verdict come back.
    task automatic wait_for_verdicts();
        @(negedge clk);
        item_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_plane_reg(input logic [CFG_INDEX_W-1:0] idx,
                                   input logic [PLANE_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_plane(idx, value);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic fill_planes(input logic [PLANE_W-1:0] value);
        for (int i = 0; i < PLANE_REGS; i++)
            write_plane_reg(i[CFG_INDEX_W-1:0], value);
    endtask

    // Axis-aligned cube of half size a around the origin, normals pointing in.
    task automatic load_box_frustum(input int a);
        write_plane_reg(REG_NEAR,   pack_plane(0, 0, UNIT_NORMAL, a));
        write_plane_reg(REG_FAR,    pack_plane(0, 0, -UNIT_NORMAL, a));
        write_plane_reg(REG_LEFT,   pack_plane(UNIT_NORMAL, 0, 0, a));
        write_plane_reg(REG_RIGHT,  pack_plane(-UNIT_NORMAL, 0, 0, a));
        write_plane_reg(REG_TOP,    pack_plane(0, -UNIT_NORMAL, 0, a));
        write_plane_reg(REG_BOTTOM, pack_plane(0, UNIT_NORMAL, 0, a));
    endtask

    task automatic run_random(input int count);
        for (int n = 0; n < count; n++)
        begin
            if (n > 0 && n % 40 == 0)
                burst = ($urandom_range(0, 3) == 0);
            offer_volume(rand_volume());
        end
        wait_for_verdicts();
    endtask

    initial
    begin
        sb = new();
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        item_valid = 1'b0;
        operation = OP_BOX;
        center_x = '0;
        center_y = '0;
        center_z = '0;
        half_x = '0;
        half_y = '0;
        half_z = '0;
        sphere_radius = '0;
        result_stall = 1'b0;
        burst = 1'b0;
        long_hold = 0;
        hold_left = 0;
        quiet_cycles = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Planes straight out of reset are all zero.
        offer_volume(make_req(OP_BOX, 32767, -32768, 32767, 32767, 32767, 32767, 0));
        offer_volume(make_req(OP_SPHERE, 0, 0, 0, 0, 0, 0, 0));
        offer_volume(make_req(OP_SPHERE, -32768, 32767, 0, 0, 0, 0, 32767));
        wait_for_verdicts();

        load_box_frustum(1000);
        offer_volume(make_req(OP_BOX, 0, 0, 0, 10, 10, 10, 0));
        offer_volume(make_req(OP_BOX, 0, 0, 0, 1500, 10, 10, 0));
        offer_volume(make_req(OP_BOX, 5000, 0, 0, 10, 10, 10, 0));
        // Box corner exactly on the plane, then one step beyond it.
        offer_volume(make_req(OP_BOX, -1100, 0, 0, 100, 0, 0, 0));
        offer_volume(make_req(OP_BOX, -1101, 0, 0, 100, 0, 0, 0));
        offer_volume(make_req(OP_BOX, -900, 0, 0, 100, 0, 0, 0));
        // Sphere touching from outside counts as intersecting.
        offer_volume(make_req(OP_SPHERE, 0, 0, 0, 0, 0, 0, 10));
        offer_volume(make_req(OP_SPHERE, -1010, 0, 0, 0, 0, 0, 10));
        offer_volume(make_req(OP_SPHERE, -1011, 0, 0, 0, 0, 0, 10));
        offer_volume(make_req(OP_SPHERE, -990, 0, 0, 0, 0, 0, 10));
        // Straddles the left plane but lies outside the later top plane.
        offer_volume(make_req(OP_SPHERE, -1005, 5000, 0, 0, 0, 0, 10));
        // Fields of the other mode must be ignored.
        offer_volume(make_req(OP_SPHERE, 0, 0, 0, 32767, 32767, 32767, 10));
        offer_volume(make_req(OP_BOX, 0, 0, 0, 0, 0, 0, 32767));
        offer_volume(make_req(OP_BOX, -32768, -32768, -32768, 32767, 32767, 32767, 0));
        offer_volume(make_req(OP_BOX, 32767, 32767, 32767, 0, 0, 0, 32767));
        offer_volume(make_req(OP_SPHERE, 0, 0, 0, 0, 0, 0, 32767));
        wait_for_verdicts();

        fill_planes(64'h7FFF_7FFF_7FFF_7FFF);
        offer_volume(make_req(OP_BOX, -32768, -32768, -32768, 32767, 32767, 32767, 0));
        offer_volume(make_req(OP_SPHERE, 32767, 32767, 32767, 0, 0, 0, 0));
        wait_for_verdicts();
        fill_planes(64'h8000_8000_8000_8000);
        offer_volume(make_req(OP_BOX, -32768, -32768, -32768, 32767, 32767, 32767, 0));
        offer_volume(make_req(OP_SPHERE, 32767, 32767, 32767, 0, 0, 0, 32767));
        wait_for_verdicts();
        fill_planes('1);
        offer_volume(make_req(OP_BOX, 32767, -32768, 0, 32767, 0, 32767, 0));
        offer_volume(make_req(OP_SPHERE, -32768, -32768, -32768, 0, 0, 0, 0));
        wait_for_verdicts();

        // The output is held off for a long stretch at the start so that the
        // pipeline backs up and stalls the request side.
        load_box_frustum($urandom_range(200, 3000));
        burst = 1'b1;
        long_hold = 80;
        run_random(RANDOM_PHASE);

        burst = 1'b0;
        for (int i = 0; i < PLANE_REGS; i++)
        begin
            write_plane_reg(i[CFG_INDEX_W-1:0],
                            pack_plane(int'($urandom_range(0, 2 * UNIT_NORMAL)) - UNIT_NORMAL,
                                       int'($urandom_range(0, 2 * UNIT_NORMAL)) - UNIT_NORMAL,
                                       int'($urandom_range(0, 2 * UNIT_NORMAL)) - UNIT_NORMAL,
                                       int'($urandom_range(0, 8000)) - 4000));
        end
        run_random(RANDOM_PHASE);

        // Writes to the unused indexes must leave the plane set untouched.
        write_plane_reg(REG_SPARE_A, {$urandom(), $urandom()});
        write_plane_reg(REG_SPARE_B, {$urandom(), $urandom()});
        for (int i = 0; i < PLANE_REGS; i++)
        begin
            write_plane_reg(i[CFG_INDEX_W-1:0],
                            ($urandom_range(0, 3) == 0) ? '0 : {$urandom(), $urandom()});
        end
        run_random(RANDOM_PHASE);

        repeat (LATENCY + 10) @(posedge clk);
        if (sb.pending() != 0)
            $display("%0d verdicts never arrived", sb.pending());
        if (sb.failures == 0 && sb.pending() == 0)
            $display("[frustum_box_sphere_cull_unit] OK");
        else
            $display("[frustum_box_sphere_cull_unit] ERROR");
        $finish;
    end

endmodule
